[src/three_class_priority_tx_scheduler_assert.svh]
// Assertion macros for the three-class priority transmit scheduler.
`ifndef THREE_CLASS_PRIORITY_TX_SCHEDULER_ASSERT_SVH
`define THREE_CLASS_PRIORITY_TX_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define TCPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcps: same-cycle check failed");

// Next-cycle implication, checked on clk, off while rst_n is low.
`define TCPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcps: next-cycle check failed");

`endif

[src/tcps_pkg.sv]
// Shared types, constants and helpers of the three-class priority scheduler.
package tcps_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int HDR_BYTES   = 24;
  localparam int NUM_CLASSES = 3;

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CLASS_W = 2;
  localparam int LEN_W   = 11;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [FILL_W-1:0]  fill_t;
  typedef logic [CLASS_W-1:0] class_t;
  typedef logic [LEN_W-1:0]   len_t;

  // Command codes
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_SERVICE = 1'b1;

  // Sink outcome codes (hint and frame)
  localparam logic [1:0] OUTCOME_NOT_READY = 2'd0;
  localparam logic [1:0] OUTCOME_REFUSED   = 2'd1;
  localparam logic [1:0] OUTCOME_ACCEPTED  = 2'd2;

  // Enqueue status codes
  localparam logic [1:0] ENQ_OK       = 2'd0;
  localparam logic [1:0] ENQ_OVERSIZE = 2'd1;
  localparam logic [1:0] ENQ_FULL     = 2'd2;

  // Class codes
  localparam class_t CLS_RESPONSE = 2'd0;
  localparam class_t CLS_EVENT    = 2'd1;
  localparam class_t CLS_DATA     = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  queue_class;
    logic [7:0]  ch_type;
    logic [7:0]  ch_id;
    logic [7:0]  opcode;
    logic [15:0] ref_seq;
    logic [15:0] msg_status;
    logic [9:0]  body_len;
    logic        link_configured;
    logic [1:0]  hint_outcome;
    logic [1:0]  frame_outcome;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  enqueue_status;
    logic        hint_valid;
    logic [2:0]  hint_pending;
    logic [2:0]  hint_dropped;
    logic        frame_valid;
    logic [1:0]  frame_class;
    logic [15:0] frame_seq;
    logic [15:0] frame_ref_seq;
    logic [15:0] frame_channel;
    logic [7:0]  frame_opcode;
    logic [15:0] frame_status;
    logic [10:0] frame_len;
  } out_word_t;

  // One queued frame descriptor
  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] ref_seq;
    logic [15:0] channel;
    logic [7:0]  opcode;
    logic [15:0] status;
    len_t        len;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
  } ctl_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage

[src/tcps_in_if.sv]
// Input word channel: valid/ready handshake with a scheduler command word.
interface tcps_in_if;
  logic               valid;
  logic               ready;
  tcps_pkg::in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[src/tcps_out_if.sv]
// Result word channel: valid/ready handshake with a scheduler result word.
interface tcps_out_if;
  logic                valid;
  logic                ready;
  tcps_pkg::out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[src/tcps_ctrl.sv]
// Handshake controller: tracks the result register and issues load commands.
module tcps_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_ready,
  output logic           in_ready,
  output logic           out_valid,
  output tcps_pkg::ctl_t ctl
);
  import tcps_pkg::*;

  typedef enum logic {
    S_EMPTY,
    S_FULL
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // A new word may enter whenever the result slot is empty or drains now.
  assign in_ready  = (state_r == S_EMPTY) || out_ready;
  assign out_valid = (state_r == S_FULL);
  assign ctl.load  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_EMPTY: begin
        if (ctl.load) begin
          state_nxt = S_FULL;
        end
      end
      S_FULL: begin
        if (ctl.load) begin
          state_nxt = S_FULL;
        end else if (out_ready) begin
          state_nxt = S_EMPTY;
        end
      end
      default: state_nxt = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/tcps_dpath.sv]
// Scheduler datapath: descriptor store, queue pointers, hint state, result register.
module tcps_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  tcps_pkg::ctl_t      ctl,
  input  tcps_pkg::in_word_t  in_word,
  input  logic                cfg_wr_en,
  input  logic [10:0]         cfg_wr_data,
  output tcps_pkg::out_word_t out_word
);
  import tcps_pkg::*;

  entry_t    store_r [NUM_CLASSES][QUEUE_DEPTH];
  ptr_t      rd_ptr_r  [NUM_CLASSES];
  ptr_t      rd_ptr_nxt[NUM_CLASSES];
  ptr_t      wr_ptr_r  [NUM_CLASSES];
  ptr_t      wr_ptr_nxt[NUM_CLASSES];
  fill_t     fill_r    [NUM_CLASSES];
  fill_t     fill_nxt  [NUM_CLASSES];
  logic [15:0] seq_r, seq_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic [2:0]  drop_r, drop_nxt;
  logic        dirty_r, dirty_nxt;
  len_t        max_len_r;
  out_word_t   res_r, res_nxt;

  logic [2:0]  cls_hit;
  logic [2:0]  nonempty;
  logic [2:0]  full;
  logic [2:0]  pend_new;
  class_t      pick;
  len_t        total;
  entry_t      head;
  entry_t      new_entry;
  logic        wr_en;

  assign out_word = res_r;

  // Per-class decode and the priority pick (class 0 wins)
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      cls_hit[c]  = (in_word.queue_class == CLASS_W'(c));
      nonempty[c] = (fill_r[c] != '0);
      full[c]     = (fill_r[c] == FILL_W'(QUEUE_DEPTH));
    end
    pick = CLS_RESPONSE;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (nonempty[c]) begin
        pick = CLASS_W'(c);
      end
    end
  end

  assign total = LEN_W'(HDR_BYTES) + LEN_W'(in_word.body_len);
  assign head  = store_r[pick][rd_ptr_r[pick]];

  // Descriptor as stored: class-dependent fields forced to zero
  always_comb begin
    new_entry.seq     = seq_r;
    new_entry.ref_seq = (in_word.queue_class == CLS_RESPONSE) ? in_word.ref_seq : 16'd0;
    new_entry.channel = {in_word.ch_type, in_word.ch_id};
    new_entry.opcode  = (in_word.queue_class == CLS_DATA) ? 8'd0 : in_word.opcode;
    new_entry.status  = (in_word.queue_class == CLS_RESPONSE) ? in_word.msg_status : 16'd0;
    new_entry.len     = total;
  end

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    fill_nxt   = fill_r;
    seq_nxt    = seq_r;
    pend_nxt   = pend_r;
    drop_nxt   = drop_r;
    dirty_nxt  = dirty_r;
    res_nxt    = res_r;
    wr_en      = 1'b0;
    pend_new   = '0;

    if (ctl.load) begin
      res_nxt = '0;
      if (in_word.cmd == CMD_ENQUEUE) begin
        if (|cls_hit) begin
          if (total > max_len_r) begin
            res_nxt.enqueue_status = ENQ_OVERSIZE;
            drop_nxt  = drop_r | cls_hit;
            dirty_nxt = 1'b1;
          end else if (|(full & cls_hit)) begin
            res_nxt.enqueue_status = ENQ_FULL;
            drop_nxt  = drop_r | cls_hit;
            dirty_nxt = 1'b1;
          end else begin
            wr_en   = 1'b1;
            seq_nxt = seq_r + 16'd1;
            for (int c = 0; c < NUM_CLASSES; c++) begin
              if (cls_hit[c]) begin
                wr_ptr_nxt[c] = ptr_inc(wr_ptr_r[c]);
                fill_nxt[c]   = fill_r[c] + fill_t'(1);
              end
            end
          end
        end
      end else if (in_word.link_configured) begin
        // hint shows the bits as they stand before any pop below
        if (dirty_r && (in_word.hint_outcome != OUTCOME_NOT_READY)) begin
          res_nxt.hint_valid   = 1'b1;
          res_nxt.hint_pending = pend_r;
          res_nxt.hint_dropped = drop_r;
          if (in_word.hint_outcome == OUTCOME_ACCEPTED) begin
            dirty_nxt = 1'b0;
            drop_nxt  = '0;
          end
        end
        if ((in_word.frame_outcome != OUTCOME_NOT_READY) && (|nonempty)) begin
          res_nxt.frame_valid   = 1'b1;
          res_nxt.frame_class   = pick;
          res_nxt.frame_seq     = head.seq;
          res_nxt.frame_ref_seq = head.ref_seq;
          res_nxt.frame_channel = head.channel;
          res_nxt.frame_opcode  = head.opcode;
          res_nxt.frame_status  = head.status;
          res_nxt.frame_len     = head.len;
          if (in_word.frame_outcome == OUTCOME_ACCEPTED) begin
            rd_ptr_nxt[pick] = ptr_inc(rd_ptr_r[pick]);
            fill_nxt[pick]   = fill_r[pick] - fill_t'(1);
          end
        end
      end

      // pending bits follow the fill counts; any change re-arms the hint
      for (int c = 0; c < NUM_CLASSES; c++) begin
        pend_new[c] = (fill_nxt[c] != '0);
      end
      if (pend_new != pend_r) begin
        pend_nxt  = pend_new;
        dirty_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[in_word.queue_class][wr_ptr_r[in_word.queue_class]] <= new_entry;
    end
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        rd_ptr_r[c] <= '0;
        wr_ptr_r[c] <= '0;
        fill_r[c]   <= '0;
      end
      seq_r     <= 16'd1;
      pend_r    <= '0;
      drop_r    <= '0;
      dirty_r   <= 1'b1;
      max_len_r <= LEN_W'(64);
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
      seq_r    <= seq_nxt;
      pend_r   <= pend_nxt;
      drop_r   <= drop_nxt;
      dirty_r  <= dirty_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

endmodule

[src/three_class_priority_tx_scheduler.sv]
// Strict-priority scheduler over three frame-descriptor queues (response, event, data).
// The result word is registered and valid in the cycle after its command word is accepted.
// Throughput: one word per cycle; a word is taken whenever the result register is
//   empty or drains in the same cycle, so the single result register sets the pace.
// Reset (rst_n low, synchronous): queues empty, sequence 1, hint dirty, frame limit 64;
//   the descriptor store is not cleared, only written entries are ever read.
module three_class_priority_tx_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  tcps_in_if.sink     in_word,
  tcps_out_if.source  out_word,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data
);
  import tcps_pkg::*;
  `include "three_class_priority_tx_scheduler_assert.svh"

  ctl_t ctl;

  // Controller owns the handshake; the datapath only sees load strobes.
  tcps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .out_ready (out_word.ready),
    .in_ready  (in_word.ready),
    .out_valid (out_word.valid),
    .ctl       (ctl)
  );

  // Store, pointers, hint bookkeeping and the registered result word.
  tcps_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .in_word     (in_word.payload),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_word    (out_word.payload)
  );

  // A stalled result blocks intake, so no result is overwritten.
  `TCPS_ASSERT_NOW(a_no_overwrite, out_word.valid && !out_word.ready, !in_word.ready)

  // A dropped enqueue presents neither a hint nor a frame.
  `TCPS_ASSERT_NOW(a_drop_quiet, out_word.valid && (out_word.payload.enqueue_status != ENQ_OK),
                   !out_word.payload.hint_valid && !out_word.payload.frame_valid)

  // Hint fields are zero when no hint is presented.
  `TCPS_ASSERT_NOW(a_hint_zero, out_word.valid && !out_word.payload.hint_valid,
                   (out_word.payload.hint_pending == 3'd0) &&
                   (out_word.payload.hint_dropped == 3'd0))

  // A presented frame was stored with a legal class and full header length.
  `TCPS_ASSERT_NOW(a_frame_sane, out_word.valid && out_word.payload.frame_valid,
                   (out_word.payload.frame_class <= CLS_DATA) &&
                   (out_word.payload.frame_len >= 11'(HDR_BYTES)))

  // An accepted command always yields a result on the next cycle.
  `TCPS_ASSERT_NEXT(a_result_follows, in_word.valid && in_word.ready, out_word.valid)

endmodule
